### src/rrpt_pkg.sv
package rrpt_pkg;

    localparam int SLOTS   = 128;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int STATE_W = 2;
    localparam int STACK_W = 64;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [STATE_W-1:0] pstate_t;
    typedef logic [STACK_W-1:0] stack_t;

    localparam pstate_t ST_FREE    = 2'd0;
    localparam pstate_t ST_READY   = 2'd1;
    localparam pstate_t ST_BLOCKED = 2'd2;
    localparam pstate_t ST_KILLED  = 2'd3;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_LOAD    = 3'd1;
    localparam logic [2:0] REQ_KILL    = 3'd2;
    localparam logic [2:0] REQ_BLOCK   = 3'd3;
    localparam logic [2:0] REQ_UNBLOCK = 3'd4;

    typedef struct packed {
        logic    en;
        slot_t   addr;
        pstate_t data;
    } st_wr_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        stack_t data;
    } stk_wr_t;

    function automatic slot_t next_slot(input slot_t s);
        return (s == slot_t'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

### src/rrpt_state_ram.sv
module rrpt_state_ram
(
    input  logic             clk,
    input  logic             rst_n,
    input  rrpt_pkg::st_wr_t wr,
    input  rrpt_pkg::slot_t  rd_addr,
    output rrpt_pkg::pstate_t rd_data
);

    rrpt_pkg::pstate_t          mem_reg [rrpt_pkg::SLOTS];
    logic [rrpt_pkg::SLOTS-1:0] valid_reg;
    rrpt_pkg::pstate_t          q_reg;
    logic                       q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        q_reg <= mem_reg[rd_addr];
    end

    // entry reads as free until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            q_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = q_vld_reg ? q_reg : rrpt_pkg::ST_FREE;

endmodule

### src/rrpt_stack_ram.sv
module rrpt_stack_ram
(
    input  logic              clk,
    input  rrpt_pkg::stk_wr_t wr,
    input  rrpt_pkg::slot_t   rd_addr,
    output rrpt_pkg::stack_t  rd_data
);

    rrpt_pkg::stack_t mem_reg [rrpt_pkg::SLOTS];
    rrpt_pkg::stack_t q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        q_reg <= mem_reg[rd_addr];
    end

    assign rd_data = q_reg;

endmodule

### src/round_robin_process_table.sv
// Tick scans (S_SCAN), reads the stack (S_RDSTK), answers (S_OUT); load scans;
// kill/block/unblock read (S_KRD), judge (S_KEVAL); unused codes end in idle.
// One request at a time; the slot scan visits one slot per cycle. Busy drops
// as done rises, so the next request is taken at the edge that ends the done
// cycle. The result is shown for one cycle on done; the receiver cannot stall.
// Reset: all slots free, current slot 0, halt_slot 0; no clearing pass.
module round_robin_process_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [6:0]  target_slot,
    input  logic [63:0] stack_in,
    output logic        done,
    output logic        status,
    output logic [6:0]  result_slot,
    output logic [63:0] stack_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_KRD   = 3'd2;
    localparam logic [2:0] S_KEVAL = 3'd3;
    localparam logic [2:0] S_RDSTK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [2:0]                 req_reg, req_next;
    logic [6:0]                 tgt_reg, tgt_next;
    rrpt_pkg::stack_t           stk_reg, stk_next;
    rrpt_pkg::slot_t            cur_reg, cur_next;
    logic [6:0]                 halt_reg;
    rrpt_pkg::slot_t            scan_addr_reg, scan_addr_next;
    logic [rrpt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       pend_vld_reg, pend_vld_next;
    rrpt_pkg::slot_t            pend_addr_reg, pend_addr_next;
    logic                       done_reg, done_next;
    logic                       status_reg, status_next;
    logic [6:0]                 slot_reg, slot_next;
    rrpt_pkg::stack_t           sout_reg, sout_next;

    rrpt_pkg::st_wr_t           st_wr;
    rrpt_pkg::stk_wr_t          stk_wr;
    rrpt_pkg::slot_t            st_rd_addr;
    rrpt_pkg::slot_t            stk_rd_addr;
    rrpt_pkg::pstate_t          st_rd;
    rrpt_pkg::stack_t           stk_rd;

    logic                       is_tick;
    logic                       issue;
    logic                       hit;
    logic                       tgt_ok;
    rrpt_pkg::pstate_t          new_state;

    rrpt_state_ram u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (st_wr),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd)
    );

    rrpt_stack_ram u_stack
    (
        .clk     (clk),
        .wr      (stk_wr),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd)
    );

    assign is_tick = (req_reg == rrpt_pkg::REQ_TICK);
    assign issue   = (cnt_reg != rrpt_pkg::CNT_W'(rrpt_pkg::SLOTS));
    assign hit     = pend_vld_reg &&
                     (is_tick ? (st_rd == rrpt_pkg::ST_READY) : (st_rd == rrpt_pkg::ST_FREE));
    assign tgt_ok  = (32'(tgt_reg) < rrpt_pkg::SLOTS) && (tgt_reg != halt_reg);

    always_comb
    begin
        unique case (req_reg)
            rrpt_pkg::REQ_KILL:  new_state = rrpt_pkg::ST_KILLED;
            rrpt_pkg::REQ_BLOCK: new_state = rrpt_pkg::ST_BLOCKED;
            default:             new_state = rrpt_pkg::ST_READY;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        tgt_next       = tgt_reg;
        stk_next       = stk_reg;
        cur_next       = cur_reg;
        scan_addr_next = scan_addr_reg;
        cnt_next       = cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        sout_next      = sout_reg;
        st_wr          = '0;
        stk_wr         = '0;
        st_rd_addr     = scan_addr_reg;
        stk_rd_addr    = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next      = req_type;
                    tgt_next      = target_slot;
                    stk_next      = stack_in;
                    pend_vld_next = 1'b0;
                    unique case (req_type)
                        rrpt_pkg::REQ_TICK:
                        begin
                            stk_wr         = '{en: 1'b1, addr: cur_reg, data: stack_in};
                            scan_addr_next = rrpt_pkg::next_slot(cur_reg);
                            cnt_next       = rrpt_pkg::CNT_W'(1);
                            state_next     = S_SCAN;
                        end
                        rrpt_pkg::REQ_LOAD:
                        begin
                            scan_addr_next = '0;
                            cnt_next       = '0;
                            state_next     = S_SCAN;
                        end
                        rrpt_pkg::REQ_KILL, rrpt_pkg::REQ_BLOCK, rrpt_pkg::REQ_UNBLOCK:
                        begin
                            state_next = S_KRD;
                        end
                        default:
                        begin
                            status_next = 1'b1;
                            slot_next   = '0;
                            sout_next   = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // reads issued one per cycle; result of previous address judged here
                if (pend_vld_reg && is_tick && (st_rd == rrpt_pkg::ST_KILLED))
                begin
                    st_wr = '{en: 1'b1, addr: pend_addr_reg, data: rrpt_pkg::ST_FREE};
                end
                if (hit)
                begin
                    pend_vld_next = 1'b0;
                    if (is_tick)
                    begin
                        cur_next   = pend_addr_reg;
                        state_next = S_RDSTK;
                    end
                    else
                    begin
                        st_wr       = '{en: 1'b1, addr: pend_addr_reg, data: rrpt_pkg::ST_READY};
                        stk_wr      = '{en: 1'b1, addr: pend_addr_reg, data: stk_reg};
                        status_next = 1'b0;
                        slot_next   = 7'(pend_addr_reg);
                        sout_next   = '0;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (!issue)
                begin
                    pend_vld_next = 1'b0;
                    if (is_tick)
                    begin
                        state_next = S_RDSTK;
                    end
                    else
                    begin
                        status_next = 1'b1;
                        slot_next   = '0;
                        sout_next   = '0;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    pend_vld_next  = 1'b1;
                    pend_addr_next = scan_addr_reg;
                    scan_addr_next = rrpt_pkg::next_slot(scan_addr_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end
            end

            S_KRD:
            begin
                st_rd_addr = rrpt_pkg::slot_t'(tgt_reg);
                state_next = S_KEVAL;
            end

            S_KEVAL:
            begin
                if (tgt_ok && (st_rd != rrpt_pkg::ST_FREE))
                begin
                    st_wr       = '{en: 1'b1, addr: rrpt_pkg::slot_t'(tgt_reg), data: new_state};
                    status_next = 1'b0;
                end
                else
                begin
                    status_next = 1'b1;
                end
                slot_next  = '0;
                sout_next  = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RDSTK:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                status_next = 1'b0;
                slot_next   = 7'(cur_reg);
                sout_next   = stk_rd;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            halt_reg     <= '0;
            pend_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            pend_vld_reg <= pend_vld_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                halt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        tgt_reg       <= tgt_next;
        stk_reg       <= stk_next;
        scan_addr_reg <= scan_addr_next;
        cnt_reg       <= cnt_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        sout_reg      <= sout_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_slot = slot_reg;
    assign stack_out   = sout_reg;

endmodule

### test/tb_top.sv
module tb_top;
    import rrpt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic   status;
        slot_t  slot;
        stack_t stack;
    } table_resp_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic [2:0] req_type    = '0;
    slot_t      target_slot = '0;
    stack_t     stack_in    = '0;
    logic       done;
    logic       status;
    slot_t      result_slot;
    stack_t     stack_out;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    slot_t      cfg_data    = '0;

    // shadow of the process table
    pstate_t     proc_state [SLOTS];
    stack_t      proc_stack [SLOTS];
    slot_t       run_slot  = '0;
    slot_t       idle_slot = '0;
    table_resp_t pending_resp [$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    bit no_idle        = 1'b0;

    round_robin_process_table dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .target_slot (target_slot),
        .stack_in    (stack_in),
        .done        (done),
        .status      (status),
        .result_slot (result_slot),
        .stack_out   (stack_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic table_resp_t table_request(input logic [2:0] kind, input slot_t tgt,
                                                  input stack_t sp);
        table_resp_t r;
        int          base;
        int          s;
        bit          hit;
        r.status = 1'b1;
        r.slot   = '0;
        r.stack  = '0;
        hit      = 1'b0;
        case (kind)
            REQ_TICK:
            begin
                base = int'(run_slot);
                proc_stack[run_slot] = sp;
                for (int i = 1; i < SLOTS && !hit; i++)
                begin
                    s = (base + i) % SLOTS;
                    if (proc_state[s] == ST_READY)
                    begin
                        run_slot = slot_t'(s);
                        hit      = 1'b1;
                    end
                    else if (proc_state[s] == ST_KILLED)
                        proc_state[s] = ST_FREE;
                end
                r.status = 1'b0;
                r.slot   = run_slot;
                r.stack  = proc_stack[run_slot];
            end
            REQ_LOAD:
            begin
                for (s = 0; s < SLOTS && !hit; s++)
                begin
                    if (proc_state[s] == ST_FREE)
                    begin
                        proc_state[s] = ST_READY;
                        proc_stack[s] = sp;
                        r.status      = 1'b0;
                        r.slot        = slot_t'(s);
                        hit           = 1'b1;
                    end
                end
            end
            REQ_KILL, REQ_BLOCK, REQ_UNBLOCK:
            begin
                if (tgt != idle_slot && proc_state[tgt] != ST_FREE)
                begin
                    proc_state[tgt] = (kind == REQ_KILL)  ? ST_KILLED :
                                      (kind == REQ_BLOCK) ? ST_BLOCKED : ST_READY;
                    r.status = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 31) == 0)
            no_idle = !no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic stack_t rand_stack();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // mostly occupied slots, sometimes the idle slot or any slot
    function automatic slot_t pick_target();
        int    r;
        slot_t t;
        r = $urandom_range(0, 19);
        if (r == 0)
            return idle_slot;
        if (r < 14)
        begin
            for (int k = 0; k < 8; k++)
            begin
                t = slot_t'($urandom_range(0, SLOTS - 1));
                if (proc_state[t] != ST_FREE)
                    return t;
            end
        end
        return slot_t'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, what);
    endfunction

    task automatic send_req(input logic [2:0] kind, input slot_t tgt, input stack_t sp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= kind;
        target_slot <= tgt;
        stack_in    <= sp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_resp.push_back(table_request(kind, tgt, sp));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_resp.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_halt(input slot_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        idle_slot = v;
    endtask

    task automatic test_directed_requests();
        send_req(REQ_TICK, '0, '1);
        send_req(REQ_KILL, 7'd5, '0);
        send_req(REQ_BLOCK, 7'd5, '0);
        send_req(REQ_UNBLOCK, 7'd127, '1);
        send_req(REQ_LOAD, '0, '0);
        send_req(REQ_LOAD, '0, '1);
        send_req(REQ_LOAD, 7'd127, 64'hA5A5_5A5A_0F0F_F0F0);
        send_req(REQ_KILL, '0, '0);
        send_req(REQ_BLOCK, '0, '0);
        send_req(REQ_UNBLOCK, '0, '0);
        send_req(REQ_BLOCK, 7'd1, '0);
        send_req(REQ_TICK, '0, rand_stack());
        send_req(REQ_KILL, 7'd2, '0);
        send_req(REQ_TICK, '0, rand_stack());
        // no ready slot: stays put, killed slot 2 freed on the way
        send_req(REQ_TICK, '0, rand_stack());
        send_req(REQ_UNBLOCK, 7'd1, '0);
        send_req(REQ_TICK, '0, rand_stack());
        send_req(REQ_LOAD, '0, rand_stack());
        send_req(3'd5, 7'd127, '1);
        send_req(3'd6, '0, '0);
        send_req(3'd7, 7'd127, '1);
        send_req(REQ_KILL, 7'd127, '1);
    endtask

    task automatic test_protected_top_slot();
        wait_idle();
        write_halt(slot_t'(SLOTS - 1));
        // fill the table, then overflow it
        for (int k = 0; k < SLOTS + 2; k++)
            send_req(REQ_LOAD, slot_t'($urandom_range(0, SLOTS - 1)), rand_stack());
        send_req(REQ_KILL, slot_t'(SLOTS - 1), '0);
        send_req(REQ_BLOCK, slot_t'(SLOTS - 1), '0);
        send_req(REQ_UNBLOCK, slot_t'(SLOTS - 1), '0);
        send_req(REQ_KILL, '0, '0);
        for (int k = 2; k < SLOTS - 1; k += 2)
            send_req(REQ_KILL, slot_t'(k), '0);
        for (int k = 0; k < 4; k++)
            send_req(REQ_TICK, '0, rand_stack());
    endtask

    task automatic test_random_phase(input slot_t halt, input int count);
        int          r;
        logic [2:0]  kind;
        wait_idle();
        write_halt(halt);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                kind = REQ_TICK;
            else if (r < 50)
                kind = REQ_LOAD;
            else if (r < 63)
                kind = REQ_KILL;
            else if (r < 76)
                kind = REQ_BLOCK;
            else if (r < 94)
                kind = REQ_UNBLOCK;
            else
                kind = 3'($urandom_range(5, 7));
            send_req(kind, pick_target(), rand_stack());
        end
    endtask

    always @(posedge clk)
    begin
        table_resp_t want;
        if (rst_n && done)
        begin
            if (pending_resp.size() == 0)
                note_mismatch($sformatf("unexpected result status=%0d slot=%0d stack=%h",
                                        status, result_slot, stack_out));
            else
            begin
                want = pending_resp.pop_front();
                if (status !== want.status || result_slot !== want.slot ||
                    stack_out !== want.stack)
                    note_mismatch($sformatf(
                        "expected status=%0d slot=%0d stack=%h, got status=%0d slot=%0d stack=%h",
                        want.status, want.slot, want.stack, status, result_slot, stack_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            proc_state[k] = ST_FREE;
            proc_stack[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_requests();
        test_protected_top_slot();
        test_random_phase(slot_t'($urandom_range(1, SLOTS - 2)), 380);
        test_random_phase('0, 380);
        test_random_phase(slot_t'(SLOTS - 1), 380);
        test_random_phase(slot_t'($urandom_range(0, SLOTS - 1)), 380);
        wait_idle();
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
